[rtl/ook_pkg.sv]
// types, constants and pulse tables shared by the pulse-code transmitter
// no dependencies; imported by ook_cfg, ook_enc and ook_pulse_code_transmitter_top
`default_nettype none

package ook_pkg;

  localparam int MAX_SYMBOLS  = 16;   // longest code word taken from a start beat
  localparam int WORD_W       = 32;
  localparam int WORD_SYMBOLS = WORD_W / 2;
  localparam int SEL_W        = $clog2(WORD_SYMBOLS);
  localparam int IDX_W        = 5;
  localparam int UNIT_W       = 7;
  localparam int UTICK_W      = 16;
  localparam int TICK_W       = UNIT_W + UTICK_W;
  localparam int PROTO_W      = 3;
  localparam int REP_W        = 8;
  localparam int ADDR_W       = 4;
  localparam int DATA_W       = 32;

  localparam logic KIND_TICK  = 1'b0;
  localparam logic KIND_START = 1'b1;

  localparam logic [1:0] SYM_ZERO  = 2'd0;
  localparam logic [1:0] SYM_ONE   = 2'd1;
  localparam logic [1:0] SYM_FLOAT = 2'd2;
  localparam logic [1:0] SYM_SKIP  = 2'd3;

  localparam logic [PROTO_W-1:0] PROTO_1 = 3'd1;
  localparam logic [PROTO_W-1:0] PROTO_2 = 3'd2;
  localparam logic [PROTO_W-1:0] PROTO_3 = 3'd3;

  localparam logic [PROTO_W-1:0] RST_PROTOCOL = PROTO_1;
  localparam logic [UTICK_W-1:0] RST_UNIT     = 16'd350;
  localparam logic [REP_W-1:0]   RST_REPEAT   = 8'd10;
  localparam logic               RST_ENABLE   = 1'b0;

  typedef enum logic [1:0] {
    REG_PROTOCOL = 2'd0,
    REG_UNIT     = 2'd1,
    REG_REPEAT   = 2'd2,
    REG_ENABLE   = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              kind;
    logic [WORD_W-1:0] symbols;
    logic [IDX_W-1:0]  symbol_count;
    logic              binary_mode;
  } cmd_t;

  typedef struct packed {
    logic pin_level;
    logic busy_res;
    logic frame_done;
  } res_t;

  typedef struct packed {
    logic [PROTO_W-1:0] protocol_select;
    logic [UTICK_W-1:0] unit_ticks;
    logic [REP_W-1:0]   repeat_count;
    logic               output_enable;
  } cfg_t;

  function automatic logic proto_known(input logic [PROTO_W-1:0] proto);
    return (proto == PROTO_1) || (proto == PROTO_2) || (proto == PROTO_3);
  endfunction

  // symbol positions past the stored word read as '0'
  function automatic logic [1:0] sym_at(input logic [WORD_W-1:0] word,
                                        input logic [IDX_W-1:0] idx);
    if (idx >= IDX_W'(WORD_SYMBOLS)) return SYM_ZERO;
    return word[{idx[SEL_W-1:0], 1'b0} +: 2];
  endfunction

  // true when the symbol sends at least one pulse pair
  function automatic logic sym_live(input logic bin, input logic [PROTO_W-1:0] proto,
                                    input logic [1:0] sym);
    if (bin) return proto_known(proto) && ((sym == SYM_ZERO) || (sym == SYM_ONE));
    return sym != SYM_SKIP;
  endfunction

  // pulse units of one segment
  function automatic logic [UNIT_W-1:0] pair_units(input logic sync, input logic [1:0] sym,
                                                   input logic bin,
                                                   input logic [PROTO_W-1:0] proto,
                                                   input logic half, input logic high);
    logic [UNIT_W-1:0] hi;
    logic [UNIT_W-1:0] lo;
    hi = '0;
    lo = '0;
    if (sync) begin
      case (proto)
        PROTO_1: begin hi = 7'd1; lo = 7'd31; end
        PROTO_2: begin hi = 7'd1; lo = 7'd10; end
        PROTO_3: begin hi = 7'd1; lo = 7'd71; end
        default: ;
      endcase
    end else if (bin) begin
      case (sym)
        SYM_ZERO: begin
          case (proto)
            PROTO_1: begin hi = 7'd1; lo = 7'd3;  end
            PROTO_2: begin hi = 7'd1; lo = 7'd2;  end
            PROTO_3: begin hi = 7'd4; lo = 7'd11; end
            default: ;
          endcase
        end
        SYM_ONE: begin
          case (proto)
            PROTO_1: begin hi = 7'd3; lo = 7'd1; end
            PROTO_2: begin hi = 7'd2; lo = 7'd1; end
            PROTO_3: begin hi = 7'd9; lo = 7'd6; end
            default: ;
          endcase
        end
        default: ;
      endcase
    end else begin
      case (sym)
        SYM_ZERO:  begin hi = 7'd1; lo = 7'd3; end
        SYM_ONE:   begin hi = 7'd3; lo = 7'd1; end
        SYM_FLOAT: begin
          if (half) begin hi = 7'd3; lo = 7'd1; end
          else begin hi = 7'd1; lo = 7'd3; end
        end
        default: ;
      endcase
    end
    return high ? hi : lo;
  endfunction

endpackage

`default_nettype wire

[rtl/ook_stream_if.sv]
// valid/ready stream channel with a typed payload
// no dependencies; payload type given at instantiation
`default_nettype none

interface ook_stream_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/ook_cfg.sv]
// apb-style configuration registers of the transmitter
// depends on ook_pkg
`default_nettype none

module ook_cfg import ook_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  reg_idx_t sel;
  logic     wr;

  assign sel    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.protocol_select <= RST_PROTOCOL;
      cfg.unit_ticks      <= RST_UNIT;
      cfg.repeat_count    <= RST_REPEAT;
      cfg.output_enable   <= RST_ENABLE;
    end else if (wr) begin
      case (sel)
        REG_PROTOCOL: cfg.protocol_select <= pwdata[PROTO_W-1:0];
        REG_UNIT:     cfg.unit_ticks      <= pwdata[UTICK_W-1:0];
        REG_REPEAT:   cfg.repeat_count    <= pwdata[REP_W-1:0];
        REG_ENABLE:   cfg.output_enable   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_PROTOCOL: prdata = DATA_W'(cfg.protocol_select);
      REG_UNIT:     prdata = DATA_W'(cfg.unit_ticks);
      REG_REPEAT:   prdata = DATA_W'(cfg.repeat_count);
      REG_ENABLE:   prdata = DATA_W'(cfg.output_enable);
      default:      prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/ook_enc.sv]
// frame state and single-pass next-segment logic of the transmitter
// depends on ook_pkg
`default_nettype none

module ook_enc import ook_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  cmd_t cmd,
  input  cfg_t cfg,
  output res_t res
);

  typedef struct packed {
    logic             stop;
    logic             in_sync;
    logic [IDX_W-1:0] idx;
    logic             half;
    logic             high;
    logic [REP_W-1:0] reps;
  } pos_t;

  logic [WORD_W-1:0] word_store;
  logic [IDX_W-1:0]  word_length;
  logic              mode_binary;
  logic [REP_W-1:0]  repeats_done;
  logic [IDX_W-1:0]  symbol_index;
  logic              pair_half;
  logic              in_sync;
  logic              high_phase;
  logic [TICK_W-1:0] ticks_left;
  logic              active;

  logic              is_start;
  logic              load;
  logic [IDX_W-1:0]  cnt_sat;
  logic [WORD_W-1:0] v_word;
  logic [IDX_W-1:0]  v_len;
  logic              v_bin;
  logic              known;
  logic [MAX_SYMBOLS-1:0] live;
  logic [IDX_W:0]    hit0;
  logic [IDX_W:0]    hitn;
  logic [REP_W-1:0]  r1;
  logic              wrap_end;
  logic              last_tick;
  pos_t              tgt;
  logic [UNIT_W-1:0] tgt_units;
  logic [TICK_W-1:0] tick_load;

  // lowest live symbol at or above from: {found, index}
  function automatic logic [IDX_W:0] find_first(input logic [MAX_SYMBOLS-1:0] v,
                                                input logic [IDX_W:0] from);
    logic             found;
    logic [IDX_W-1:0] idx;
    found = 1'b0;
    idx   = '0;
    for (int i = MAX_SYMBOLS - 1; i >= 0; i--) begin
      if (v[i] && ((IDX_W+1)'(i) >= from)) begin
        found = 1'b1;
        idx   = IDX_W'(i);
      end
    end
    return {found, idx};
  endfunction

  assign is_start  = cmd.kind == KIND_START;
  assign load      = is_start && !active;
  assign cnt_sat   = ({1'b0, cmd.symbol_count} > (IDX_W+1)'(MAX_SYMBOLS)) ?
                     IDX_W'(MAX_SYMBOLS) : cmd.symbol_count;
  assign v_word    = load ? cmd.symbols : word_store;
  assign v_len     = load ? cnt_sat : word_length;
  assign v_bin     = load ? cmd.binary_mode : mode_binary;
  assign known     = proto_known(cfg.protocol_select);
  assign r1        = repeats_done + REP_W'(1);
  assign wrap_end  = r1 >= cfg.repeat_count;
  assign last_tick = ticks_left == TICK_W'(1);

  always_comb begin
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      live[i] = (i < int'(v_len)) &&
                sym_live(v_bin, cfg.protocol_select, sym_at(v_word, IDX_W'(i)));
    end
  end

  assign hit0 = find_first(live, '0);
  assign hitn = find_first(live, {1'b0, symbol_index} + (IDX_W+1)'(1));

  // next position that carries pulses; zero-length pairs and empty repeats are jumped
  always_comb begin
    tgt = '{stop: 1'b0, in_sync: in_sync, idx: symbol_index, half: pair_half,
            high: 1'b1, reps: repeats_done};
    if (load) begin
      tgt.reps = '0;
      tgt.half = 1'b0;
      tgt.idx  = '0;
      if (!cfg.output_enable || (cfg.repeat_count == '0) ||
          (v_bin && (v_len == '0)) || (cfg.unit_ticks == '0)) begin
        tgt.stop = 1'b1;
      end else if (hit0[IDX_W]) begin
        tgt.in_sync = 1'b0;
        tgt.idx     = hit0[IDX_W-1:0];
      end else if (known) begin
        tgt.in_sync = 1'b1;
      end else begin
        tgt.stop = 1'b1;
      end
    end else if (high_phase) begin
      tgt.high = 1'b0;
    end else if (in_sync) begin
      tgt.idx  = '0;
      tgt.half = 1'b0;
      tgt.reps = r1;
      if (wrap_end) begin
        tgt.stop = 1'b1;
      end else if (hit0[IDX_W]) begin
        tgt.in_sync = 1'b0;
        tgt.idx     = hit0[IDX_W-1:0];
      end else if (!known) begin
        tgt.stop = 1'b1;
      end
    end else if (!mode_binary && !pair_half) begin
      tgt.half = 1'b1;
    end else begin
      tgt.half = 1'b0;
      if (hitn[IDX_W]) begin
        tgt.idx = hitn[IDX_W-1:0];
      end else if (known) begin
        tgt.in_sync = 1'b1;
      end else begin
        tgt.reps = r1;
        tgt.idx  = hit0[IDX_W-1:0];
        if (wrap_end || !hit0[IDX_W]) tgt.stop = 1'b1;
      end
    end
  end

  assign tgt_units = pair_units(tgt.in_sync, sym_at(v_word, tgt.idx), v_bin,
                                cfg.protocol_select, tgt.half, tgt.high);
  assign tick_load = TICK_W'(tgt_units) * TICK_W'(cfg.unit_ticks);

  always_comb begin
    res = '0;
    if (is_start) begin
      if (active) begin
        res.pin_level = high_phase;
        res.busy_res  = 1'b1;
      end else begin
        res.pin_level  = !tgt.stop;
        res.busy_res   = !tgt.stop;
        res.frame_done = tgt.stop;
      end
    end else if (active) begin
      if (!cfg.output_enable) begin
        res.frame_done = 1'b1;
      end else begin
        res.pin_level  = high_phase;
        res.busy_res   = !(last_tick && tgt.stop);
        res.frame_done = last_tick && tgt.stop;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (step) begin
      if (load) begin
        active <= !tgt.stop;
      end else if (!is_start && active) begin
        if (!cfg.output_enable || (last_tick && tgt.stop)) active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      if (load) begin
        word_store  <= cmd.symbols;
        word_length <= cnt_sat;
        mode_binary <= cmd.binary_mode;
      end
      if (load || (!is_start && active && cfg.output_enable && last_tick)) begin
        in_sync      <= tgt.in_sync;
        symbol_index <= tgt.idx;
        pair_half    <= tgt.half;
        high_phase   <= tgt.high;
        repeats_done <= tgt.reps;
        ticks_left   <= tick_load;
      end else if (!is_start && active) begin
        ticks_left <= ticks_left - TICK_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/ook_pulse_code_transmitter_top.sv]
// top level of the ook pulse-code transmitter: item and result registers around the encoder
// depends on ook_pkg, ook_stream_if, ook_cfg and ook_enc
`default_nettype none

// Pulse-code transmitter for tri-state or binary remote-control code words.
// A start beat on cmd while no frame runs loads up to 16 two-bit symbols and
// the encoding mode; every following tick beat is one time tick of the radio
// data pin, and each tick beat returns one result beat giving the pin level for
// that tick, whether the frame is still busy, and a done flag on the beat that
// ends the frame. Every beat on cmd gives exactly one beat on res. One item is
// taken per clock cycle, sustained, while res is ready; a taken beat is held in
// the input register and its result is registered in the res register, the
// encoder's next-segment logic (zero-length skip search, pulse table, unit
// multiply) lying between those two registers. The res register lets a new item
// enter while a finished result waits. Protocol, tick length, repeat count and
// output enable sit in APB registers at byte addresses 0, 4, 8 and 12; write
// them only while no frame is running.

module ook_pulse_code_transmitter_top import ook_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ook_stream_if.sink        cmd,
  ook_stream_if.source      res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  // input register
  cmd_t cmd_q;
  logic cmd_vld;

  // result register
  res_t res_d;
  res_t res_q;
  logic res_vld;

  // the buffered item is processed when the result register can take its result
  logic advance;

  assign advance   = cmd_vld && (!res_vld || res.ready);
  assign cmd.ready = !cmd_vld || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_vld <= 1'b0;
    end else if (cmd.ready) begin
      cmd_vld <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) cmd_q <= cmd.data;
  end

  ook_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // frame state advances once per processed item
  ook_enc u_enc (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .cmd  (cmd_q),
    .cfg  (cfg),
    .res  (res_d)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_vld <= 1'b0;
    end else if (advance) begin
      res_vld <= 1'b1;
    end else if (res.ready) begin
      res_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res_q <= res_d;
  end

  assign res.valid = res_vld;
  assign res.data  = res_q;

endmodule

`default_nettype wire

[rtl/ook_chk.sv]
// port-level checks of the transmitter, attached to the top level by bind
// depends on ook_pulse_code_transmitter_top
`default_nettype none

module ook_chk (
  input logic clk,
  input logic rst,
  input logic cmd_valid,
  input logic cmd_ready,
  input logic res_valid,
  input logic res_ready,
  input logic res_pin,
  input logic res_busy,
  input logic res_done
);

  // a taken item must show a result beat once it has passed the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |-> ##2 res_valid)
    else $error("no result two cycles after a taken item");

  // a new result only follows a taken item
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(cmd_valid && cmd_ready, 2))
    else $error("result beat without a taken item");

  // outside a frame the pin stays low
  a_idle_low: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_busy && !res_done |-> !res_pin)
    else $error("pin high on an idle result");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable({res_pin, res_busy, res_done}))
    else $error("stalled result beat changed");

endmodule

bind ook_pulse_code_transmitter_top ook_chk u_ook_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_valid (cmd.valid),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_pin   (res.data.pin_level),
  .res_busy  (res.data.busy_res),
  .res_done  (res.data.frame_done)
);

`default_nettype wire
